>>> hdl/kcc_pkg.sv
// Shared types and constants of the keypad calculator controller.
package kcc_pkg;

    localparam int VAL_W = 25;
    localparam int ACC_W = 2 * VAL_W;
    localparam int DIV_STEPS = VAL_W;
    localparam int CNT_W = $clog2(DIV_STEPS);

    localparam logic signed [VAL_W-1:0] VAL_MAX = 25'sd9999999;
    localparam logic signed [VAL_W-1:0] VAL_MIN_ENTRY = -25'sd9999999;
    localparam logic signed [ACC_W-1:0] ACC_MAX = 50'sd9999999;
    localparam logic signed [ACC_W-1:0] ACC_MIN = -50'sd999999;
    localparam logic [1:0] CUR_MAX = 2'd3;

    // Event codes as they arrive on the input channel.
    typedef enum logic [3:0] {
        OP_DIGIT  = 4'd0,
        OP_ARITH  = 4'd1,
        OP_EQUALS = 4'd2,
        OP_CLEAR  = 4'd3,
        OP_ENTER  = 4'd4,
        OP_UP     = 4'd5,
        OP_DOWN   = 4'd6,
        OP_LEFT   = 4'd7,
        OP_RIGHT  = 4'd8
    } t_op;

    // Resolved key after the cursor grid lookup.
    typedef enum logic [3:0] {
        K_DIGIT,
        K_ARITH,
        K_EQUALS,
        K_CLEAR,
        K_UP,
        K_DOWN,
        K_LEFT,
        K_RIGHT,
        K_NONE
    } t_key;

    typedef enum logic [2:0] {
        HOLD_NONE = 3'd0,
        HOLD_ADD  = 3'd1,
        HOLD_SUB  = 3'd2,
        HOLD_MUL  = 3'd3,
        HOLD_DIV  = 3'd4
    } t_hold;

    // Datapath actions, one per microcode step.
    typedef enum logic [3:0] {
        A_NOP,
        A_DIGIT,
        A_ARITH,
        A_CLEAR,
        A_CURSOR,
        A_LOAD_SHOWN,
        A_ADD,
        A_SUB,
        A_MUL,
        A_DIV_INIT,
        A_DIV_STEP,
        A_DIV_FIX,
        A_COMMIT
    } t_alu;

    typedef struct packed {
        t_alu alu;
        logic emit;
    } t_ctrl;

    typedef struct packed {
        t_key  key;
        logic  val_ok;
        t_hold held;
    } t_status;

    typedef struct packed {
        t_hold                    held;
        logic [1:0]               col;
        logic [1:0]               row;
        logic signed [VAL_W-1:0]  display;
    } t_result;

endpackage

>>> hdl/kcc_seq.sv
// Microcode sequencer: program ROM, step counter, loop counter and jumps.
module kcc_seq
    import kcc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_out_free,
    input  t_status i_status,
    output t_ctrl   o_ctrl,
    output logic    o_in_ready
);

    typedef logic [3:0] t_addr;

    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_WAIT,
        J_DISPATCH,
        J_LOOP,
        J_EMIT
    } t_jmp;

    typedef struct packed {
        t_alu  alu;
        t_jmp  jmp;
        t_addr target;
        logic  cnt_load;
    } t_uword;

    localparam t_addr ADR_WAIT     = 4'd0;
    localparam t_addr ADR_DECODE   = 4'd1;
    localparam t_addr ADR_DIGIT    = 4'd2;
    localparam t_addr ADR_ARITH    = 4'd3;
    localparam t_addr ADR_CLEAR    = 4'd4;
    localparam t_addr ADR_CURSOR   = 4'd5;
    localparam t_addr ADR_EQ_NONE  = 4'd6;
    localparam t_addr ADR_EQ_ADD   = 4'd7;
    localparam t_addr ADR_EQ_SUB   = 4'd8;
    localparam t_addr ADR_EQ_MUL   = 4'd9;
    localparam t_addr ADR_EQ_DIV   = 4'd10;
    localparam t_addr ADR_DIV_STEP = 4'd11;
    localparam t_addr ADR_DIV_FIX  = 4'd12;
    localparam t_addr ADR_COMMIT   = 4'd13;
    localparam t_addr ADR_EMIT     = 4'd14;

    function automatic t_uword urom(input t_addr a);
        t_uword w;
        w = '{alu: A_NOP, jmp: J_GOTO, target: ADR_WAIT, cnt_load: 1'b0};
        unique case (a)
            ADR_WAIT:     w = '{A_NOP,        J_WAIT,     ADR_DECODE,   1'b0};
            ADR_DECODE:   w = '{A_NOP,        J_DISPATCH, ADR_EMIT,     1'b0};
            ADR_DIGIT:    w = '{A_DIGIT,      J_GOTO,     ADR_EMIT,     1'b0};
            ADR_ARITH:    w = '{A_ARITH,      J_GOTO,     ADR_EMIT,     1'b0};
            ADR_CLEAR:    w = '{A_CLEAR,      J_GOTO,     ADR_EMIT,     1'b0};
            ADR_CURSOR:   w = '{A_CURSOR,     J_GOTO,     ADR_EMIT,     1'b0};
            ADR_EQ_NONE:  w = '{A_LOAD_SHOWN, J_GOTO,     ADR_COMMIT,   1'b0};
            ADR_EQ_ADD:   w = '{A_ADD,        J_GOTO,     ADR_COMMIT,   1'b0};
            ADR_EQ_SUB:   w = '{A_SUB,        J_GOTO,     ADR_COMMIT,   1'b0};
            ADR_EQ_MUL:   w = '{A_MUL,        J_GOTO,     ADR_COMMIT,   1'b0};
            ADR_EQ_DIV:   w = '{A_DIV_INIT,   J_NEXT,     ADR_DIV_STEP, 1'b1};
            ADR_DIV_STEP: w = '{A_DIV_STEP,   J_LOOP,     ADR_DIV_STEP, 1'b0};
            ADR_DIV_FIX:  w = '{A_DIV_FIX,    J_NEXT,     ADR_COMMIT,   1'b0};
            ADR_COMMIT:   w = '{A_COMMIT,     J_NEXT,     ADR_EMIT,     1'b0};
            ADR_EMIT:     w = '{A_NOP,        J_EMIT,     ADR_WAIT,     1'b0};
            default:      w = '{A_NOP,        J_GOTO,     ADR_WAIT,     1'b0};
        endcase
        return w;
    endfunction

    t_addr            r_pc, n_pc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_uword           w_word;
    t_addr            w_dispatch;

    // Entry point of the routine for the latched key.
    always_comb begin
        w_dispatch = ADR_EMIT;
        unique case (i_status.key)
            K_DIGIT:  w_dispatch = i_status.val_ok ? ADR_DIGIT : ADR_EMIT;
            K_ARITH:  w_dispatch = ADR_ARITH;
            K_CLEAR:  w_dispatch = ADR_CLEAR;
            K_UP, K_DOWN, K_LEFT, K_RIGHT: w_dispatch = ADR_CURSOR;
            K_EQUALS: begin
                unique case (i_status.held)
                    HOLD_ADD: w_dispatch = ADR_EQ_ADD;
                    HOLD_SUB: w_dispatch = ADR_EQ_SUB;
                    HOLD_MUL: w_dispatch = ADR_EQ_MUL;
                    HOLD_DIV: w_dispatch = ADR_EQ_DIV;
                    default:  w_dispatch = ADR_EQ_NONE;
                endcase
            end
            default:  w_dispatch = ADR_EMIT;
        endcase
    end

    always_comb begin
        w_word = urom(r_pc);
        n_pc = r_pc + 4'd1;
        n_cnt = r_cnt;
        o_ctrl.alu = w_word.alu;
        o_ctrl.emit = 1'b0;
        if (w_word.cnt_load) begin
            n_cnt = CNT_W'(DIV_STEPS - 1);
        end
        unique case (w_word.jmp)
            J_NEXT:     n_pc = r_pc + 4'd1;
            J_GOTO:     n_pc = w_word.target;
            J_WAIT:     n_pc = i_accept ? w_word.target : r_pc;
            J_DISPATCH: n_pc = w_dispatch;
            J_LOOP: begin
                if (r_cnt != '0) begin
                    n_pc = w_word.target;
                    n_cnt = r_cnt - CNT_W'(1);
                end else begin
                    n_pc = r_pc + 4'd1;
                end
            end
            J_EMIT: begin
                if (i_out_free) begin
                    o_ctrl.emit = 1'b1;
                    n_pc = w_word.target;
                end else begin
                    n_pc = r_pc;
                end
            end
            default:    n_pc = ADR_WAIT;
        endcase
    end

    assign o_in_ready = (r_pc == ADR_WAIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ADR_WAIT;
            r_cnt <= '0;
        end else begin
            r_pc <= n_pc;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> hdl/kcc_dp.sv
// Calculator datapath: key decode, entry and result registers, multiplier, divider.
module kcc_dp
    import kcc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [3:0] i_op,
    input  logic [3:0] i_digit,
    input  logic [1:0] i_arith_key,
    input  t_ctrl      i_ctrl,
    output t_status    o_status,
    output t_result    o_result
);

    typedef struct packed {
        t_key       key;
        logic [3:0] val;
    } t_gkey;

    // Key under the cursor on the 4x4 grid.
    function automatic t_gkey grid_key(input logic [1:0] row, input logic [1:0] col);
        t_gkey g;
        if (col == 2'd3) begin
            g = '{key: K_ARITH, val: {2'b00, row}};
        end else if (row != 2'd3) begin
            g = '{key: K_DIGIT, val: 4'({2'b00, row} * 4'd3 + {2'b00, col} + 4'd1)};
        end else if (col == 2'd0) begin
            g = '{key: K_DIGIT, val: 4'd0};
        end else if (col == 2'd1) begin
            g = '{key: K_EQUALS, val: 4'd0};
        end else begin
            g = '{key: K_CLEAR, val: 4'd0};
        end
        return g;
    endfunction

    function automatic logic signed [ACC_W-1:0] sext(input logic signed [VAL_W-1:0] x);
        return $signed({{(ACC_W - VAL_W){x[VAL_W-1]}}, x});
    endfunction

    function automatic logic [VAL_W-1:0] mag(input logic signed [VAL_W-1:0] x);
        return x[VAL_W-1] ? VAL_W'(-x) : VAL_W'(x);
    endfunction

    logic [1:0]               r_row, r_col;
    logic signed [VAL_W-1:0]  r_entry, r_stored, r_shown;
    t_hold                    r_held;
    t_key                     r_key;
    logic [3:0]               r_val;
    logic signed [ACC_W-1:0]  r_acc;
    logic [VAL_W:0]           r_rem;
    logic [VAL_W-1:0]         r_quo, r_div;
    logic                     r_neg, r_dz;

    t_gkey                    w_in;
    logic signed [VAL_W+4:0]  w_dext, w_dnext;
    logic                     w_dok;
    logic [VAL_W:0]           w_trial;
    logic                     w_ge;
    logic [ACC_W-1:0]         w_qx;
    logic signed [ACC_W-1:0]  w_clamp;

    always_comb begin
        unique case (t_op'(i_op))
            OP_DIGIT:  w_in = '{key: K_DIGIT, val: i_digit};
            OP_ARITH:  w_in = '{key: K_ARITH, val: {2'b00, i_arith_key}};
            OP_EQUALS: w_in = '{key: K_EQUALS, val: 4'd0};
            OP_CLEAR:  w_in = '{key: K_CLEAR, val: 4'd0};
            OP_ENTER:  w_in = grid_key(r_row, r_col);
            OP_UP:     w_in = '{key: K_UP, val: 4'd0};
            OP_DOWN:   w_in = '{key: K_DOWN, val: 4'd0};
            OP_LEFT:   w_in = '{key: K_LEFT, val: 4'd0};
            OP_RIGHT:  w_in = '{key: K_RIGHT, val: 4'd0};
            default:   w_in = '{key: K_NONE, val: 4'd0};
        endcase
    end

    // Appending a digit: entry * 10 + d, kept only while inside the entry range.
    always_comb begin
        w_dext = $signed({{5{r_entry[VAL_W-1]}}, r_entry});
        w_dnext = (w_dext <<< 3) + (w_dext <<< 1) + $signed({{(VAL_W + 1){1'b0}}, r_val});
        w_dok = (w_dnext <= (VAL_W + 5)'(VAL_MAX)) && (w_dnext >= (VAL_W + 5)'(VAL_MIN_ENTRY));
    end

    // One restoring step of the unsigned magnitude division.
    always_comb begin
        w_trial = {r_rem[VAL_W-1:0], r_quo[VAL_W-1]};
        w_ge = (w_trial >= {1'b0, r_div});
        w_qx = {{(ACC_W - VAL_W){1'b0}}, r_quo};
    end

    always_comb begin
        if (r_acc > ACC_MAX) begin
            w_clamp = ACC_MAX;
        end else if (r_acc < ACC_MIN) begin
            w_clamp = ACC_MIN;
        end else begin
            w_clamp = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_entry <= '0;
            r_stored <= '0;
            r_shown <= '0;
            r_held <= HOLD_NONE;
        end else begin
            unique case (i_ctrl.alu)
                A_DIGIT: begin
                    r_shown <= '0;
                    if (w_dok) begin
                        r_entry <= w_dnext[VAL_W-1:0];
                    end
                end
                A_ARITH: begin
                    r_stored <= r_entry;
                    r_shown <= r_entry;
                    r_entry <= '0;
                    r_held <= t_hold'(3'({1'b0, r_val[1:0]}) + 3'd1);
                end
                A_CLEAR: begin
                    r_entry <= '0;
                    r_shown <= '0;
                end
                A_CURSOR: begin
                    unique case (r_key)
                        K_UP:    if (r_row != 2'd0) r_row <= r_row - 2'd1;
                        K_DOWN:  if (r_row != CUR_MAX) r_row <= r_row + 2'd1;
                        K_LEFT:  if (r_col != 2'd0) r_col <= r_col - 2'd1;
                        K_RIGHT: if (r_col != CUR_MAX) r_col <= r_col + 2'd1;
                        default: ;
                    endcase
                end
                A_COMMIT: begin
                    r_shown <= w_clamp[VAL_W-1:0];
                    r_entry <= w_clamp[VAL_W-1:0];
                    r_held <= HOLD_NONE;
                end
                default: ;
            endcase
        end
    end

    // Latched key and scratch registers of the arithmetic routines.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_key <= w_in.key;
            r_val <= w_in.val;
        end
        unique case (i_ctrl.alu)
            A_LOAD_SHOWN: r_acc <= sext(r_shown);
            A_ADD:        r_acc <= sext(r_stored) + sext(r_entry);
            A_SUB:        r_acc <= sext(r_stored) - sext(r_entry);
            A_MUL:        r_acc <= sext(r_stored) * sext(r_entry);
            A_DIV_INIT: begin
                r_quo <= mag(r_stored);
                r_div <= mag(r_entry);
                r_rem <= '0;
                r_neg <= r_stored[VAL_W-1] ^ r_entry[VAL_W-1];
                r_dz <= (r_entry == '0);
            end
            A_DIV_STEP: begin
                r_rem <= w_ge ? (w_trial - {1'b0, r_div}) : w_trial;
                r_quo <= {r_quo[VAL_W-2:0], w_ge};
            end
            A_DIV_FIX: begin
                if (r_dz) begin
                    r_acc <= '0;
                end else if (r_neg) begin
                    r_acc <= $signed(-w_qx);
                end else begin
                    r_acc <= $signed(w_qx);
                end
            end
            default: ;
        endcase
    end

    assign o_status.key = r_key;
    assign o_status.val_ok = (r_val <= 4'd9);
    assign o_status.held = r_held;

    assign o_result.display = (r_shown != '0) ? r_shown : r_entry;
    assign o_result.row = r_row;
    assign o_result.col = r_col;
    assign o_result.held = r_held;

endmodule

>>> hdl/keypad_calculator_controller_unit.sv
// Keypad calculator controller: top level with the output register.
//
// One keypad event enters on the s_axis channel (tuser carries the event code,
// tdata the digit and arithmetic key) and gives exactly one result item on the
// m_axis channel: display value, cursor row and column, and pending operator.
// The input is taken only while the sequencer waits at its first step; the
// result item is loaded into an output register, and the next event is taken
// in the cycle after that.
// After an accept the sequencer decodes the event and runs its routine before
// the emit step: an ignored or undefined event goes straight to emit; digits,
// arithmetic keys, clear, enter on those keys and cursor moves take one datapath
// step; equals with add, subtract, multiply or no operator takes the operation
// and a commit step; equals with divide takes an init step, the one-bit-per-cycle
// divider running 25 steps in a microcode loop, a sign fix and a commit step.
// A synchronous reset clears the cursor, the entry, stored and shown values, the
// pending operator and m_axis_tvalid. While the receiver stalls, the result item
// holds; one more event may still be taken and worked, and the sequencer then
// waits at its emit step with s_axis_tready low until the held item leaves.
module keypad_calculator_controller_unit
    import kcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] digit, [5:4] arith_key, [7:6] zero
    input  logic [3:0]  s_axis_tuser,   // [3:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [24:0] display_value, [26:25] cursor_row,
                                        // [28:27] cursor_col, [31:29] pending_op
);

    logic    w_accept;
    logic    w_out_free;
    logic    w_in_ready;
    t_ctrl   w_ctrl;
    t_status w_status;
    t_result w_result;

    logic        r_m_valid;
    logic [31:0] r_m_data;

    assign w_accept = s_axis_tvalid && w_in_ready;
    assign w_out_free = !r_m_valid || m_axis_tready;

    kcc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_ctrl     (w_ctrl),
        .o_in_ready (w_in_ready)
    );

    kcc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_op        (s_axis_tuser),
        .i_digit     (s_axis_tdata[3:0]),
        .i_arith_key (s_axis_tdata[5:4]),
        .i_ctrl      (w_ctrl),
        .o_status    (w_status),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_ctrl.emit) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.emit) begin
            r_m_data <= w_result;
        end
    end

    assign s_axis_tready = w_in_ready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata = r_m_data;

endmodule

>>> hdl/kcc_checker.sv
// Port-level checks of the keypad calculator controller and their binding.
module kcc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // Reset leaves no result item behind.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result item valid after reset");

    // One item is worked on at a time: the input closes right after an accept.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again while an item is in work");

    // The input never opens while a stalled result would be overwritten next.
    a_no_accept_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid || m_axis_tready ||
            $stable(m_axis_tdata))
        else $error("stalled result changed after an accept");

    // A stalled result item holds.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result item changed");

    // The pending operator is none or one of the four operators.
    a_pending_op_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:29] <= 3'd4)
        else $error("pending operator out of range");

endmodule

bind keypad_calculator_controller_unit kcc_checker u_kcc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
